@@ src/nss_pkg.sv @@
// shared types, constants and codes of the nearest sample search block
// depends on nothing; every other file of the block but nss_ram imports it

package nss_pkg;

  // default table depth and fixed field widths
  localparam int DEPTH_DEF = 1024;
  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 18;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int OP_W      = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 2'd2;

  // operation codes of an input transaction
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // configuration reset values: 200.0, 1.5 and about 0.16
  localparam logic signed [DATA_W-1:0] MIN_X_RST    = 32'sd13107200;
  localparam logic [GAIN_W-1:0]        Y_GAIN_RST   = 18'd98304;
  localparam logic signed [DATA_W-1:0] Y_OFFSET_RST = 32'sd10486;

  // half an lsb of the q16.16 result, for round half up
  localparam int ROUND_HALF = 2 ** (FRAC_W - 1);

  // one stored sample
  typedef struct packed {
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] x;
  } entry_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_MUL,
    S_LD_RND,
    S_LD_WR,
    S_Q_START,
    S_Q_HI,
    S_Q_LO,
    S_Q_MID,
    S_Q_PREV,
    S_Q_CMP,
    S_Q_DEC,
    S_Q_OUT
  } state_t;

  // sample memory read address source
  typedef enum logic [1:0] {
    RD_FIRST,
    RD_LAST,
    RD_MID,
    RD_PREV
  } rd_sel_t;

  // source of the query result
  typedef enum logic [2:0] {
    RES_EMPTY,
    RES_FIRST,
    RES_LAST,
    RES_CUR,
    RES_PREV
  } res_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     cap_item;
    logic     clear;
    logic     ld_mul;
    logic     ld_rnd;
    logic     ld_wr;
    rd_sel_t  rd_sel;
    logic     win_init;
    logic     mid_calc;
    logic     cap_cur;
    logic     cmp_load;
    logic     win_lo;
    logic     win_hi;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } nss_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic empty;
    logic ge_last;
    logic le_first;
    logic between;
    logic near_prev;
    logic key_gt;
    logic key_lt;
    logic lo_eq_mid;
    logic hi_eq_mid;
    logic out_free;
  } nss_sts_t;

endpackage

@@ src/nss_if.sv @@
// valid/ready channel interfaces for input items and query results
// depends on nss_pkg for the field widths

interface nss_in_if
  import nss_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] sample_x;
  logic signed [DATA_W-1:0] sample_y;
  logic signed [DATA_W-1:0] key;

  modport source (output valid, op, sample_x, sample_y, key, input ready);
  modport sink (input valid, op, sample_x, sample_y, key, output ready);
endinterface

interface nss_out_if
  import nss_pkg::*;
  #(parameter int IDX_W = $clog2(DEPTH_DEF))
  ();
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [IDX_W-1:0]         index;
  logic signed [DATA_W-1:0] near_x;
  logic signed [DATA_W-1:0] near_y;

  modport source (output valid, found, index, near_x, near_y, input ready);
  modport sink (input valid, found, index, near_x, near_y, output ready);
endinterface

@@ src/nss_ram.sv @@
// generic single write, single read ram with registered read data
// depends on nothing

module nss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/nss_ctrl.sv @@
// controller of the nearest sample search: sequences load, clear and query
// depends on nss_pkg for states, codes and the command/status structs

module nss_ctrl
  import nss_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  input  nss_sts_t        sts,
  output nss_cmd_t        cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = in_valid && (state_r == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_LOAD) begin
            state_nxt = S_LD_MUL;
          end else if (in_op == OP_QUERY) begin
            state_nxt = S_Q_START;
          end
        end
      end
      S_LD_MUL:  state_nxt = S_LD_RND;
      S_LD_RND:  state_nxt = S_LD_WR;
      S_LD_WR:   state_nxt = S_IDLE;
      S_Q_START: state_nxt = sts.empty ? S_Q_OUT : S_Q_HI;
      S_Q_HI:    state_nxt = sts.ge_last ? S_Q_OUT : S_Q_LO;
      S_Q_LO:    state_nxt = sts.le_first ? S_Q_OUT : S_Q_MID;
      S_Q_MID:   state_nxt = S_Q_PREV;
      S_Q_PREV:  state_nxt = S_Q_CMP;
      S_Q_CMP:   state_nxt = S_Q_DEC;
      S_Q_DEC: begin
        priority if (sts.between) begin
          state_nxt = S_Q_OUT;
        end else if (sts.key_gt) begin
          state_nxt = sts.lo_eq_mid ? S_Q_OUT : S_Q_MID;
        end else if (sts.key_lt) begin
          state_nxt = sts.hi_eq_mid ? S_Q_OUT : S_Q_MID;
        end else begin
          state_nxt = S_Q_OUT;
        end
      end
      S_Q_OUT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd         = '0;
    cmd.rd_sel  = RD_FIRST;
    cmd.res_sel = RES_CUR;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.cap_item = accept;
        cmd.clear    = accept && (in_op == OP_CLEAR);
      end
      S_LD_MUL: cmd.ld_mul = 1'b1;
      S_LD_RND: cmd.ld_rnd = 1'b1;
      S_LD_WR:  cmd.ld_wr  = 1'b1;
      S_Q_START: begin
        cmd.rd_sel   = RD_LAST;
        cmd.win_init = 1'b1;
        cmd.res_load = sts.empty;
        cmd.res_sel  = RES_EMPTY;
      end
      S_Q_HI: begin
        cmd.rd_sel   = RD_FIRST;
        cmd.res_load = sts.ge_last;
        cmd.res_sel  = RES_LAST;
      end
      S_Q_LO: begin
        cmd.res_load = sts.le_first;
        cmd.res_sel  = RES_FIRST;
      end
      S_Q_MID: begin
        cmd.rd_sel   = RD_MID;
        cmd.mid_calc = 1'b1;
      end
      S_Q_PREV: begin
        cmd.rd_sel  = RD_PREV;
        cmd.cap_cur = 1'b1;
      end
      S_Q_CMP: cmd.cmp_load = 1'b1;
      S_Q_DEC: begin
        priority if (sts.between) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = sts.near_prev ? RES_PREV : RES_CUR;
        end else if (sts.key_gt) begin
          cmd.res_load = sts.lo_eq_mid;
          cmd.win_lo   = !sts.lo_eq_mid;
        end else if (sts.key_lt) begin
          cmd.res_load = sts.hi_eq_mid;
          cmd.win_hi   = !sts.hi_eq_mid;
        end else begin
          cmd.res_load = 1'b1;
        end
      end
      S_Q_OUT: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

`ifndef NO_ASSERTIONS
  // a finished result leaves the controller free for the next transaction
  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q_OUT && sts.out_free) |=> (state_r == S_IDLE))
    else $error("query did not return to idle after result hand-off");

  // an accepted query always starts its search
  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == OP_QUERY) |=> (state_r == S_Q_START))
    else $error("accepted query did not start");
`endif

endmodule

@@ src/nss_dp.sv @@
// datapath of the nearest sample search: config, sample memory, scaling,
// bisection window, compares and result registers; depends on nss_pkg, nss_ram

module nss_dp
  import nss_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]            cfg_wdata,
  input  logic signed [DATA_W-1:0]     in_sample_x,
  input  logic signed [DATA_W-1:0]     in_sample_y,
  input  logic signed [DATA_W-1:0]     in_key,
  input  nss_cmd_t                     cmd,
  output nss_sts_t                     sts,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         out_found,
  output logic [$clog2(DEPTH)-1:0]     out_index,
  output logic signed [DATA_W-1:0]     out_near_x,
  output logic signed [DATA_W-1:0]     out_near_y
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int PW   = DATA_W + GAIN_W + 1;
  localparam int RW   = PW - FRAC_W;
  localparam int DW   = DATA_W + 1;

  // configuration registers
  logic signed [DATA_W-1:0] min_x_r;
  logic [GAIN_W-1:0]        y_gain_r;
  logic signed [DATA_W-1:0] y_offset_r;

  // captured transaction
  logic signed [DATA_W-1:0] x_r;
  logic signed [DATA_W-1:0] y_r;
  logic signed [DATA_W-1:0] key_r;

  // table fill and scaling pipeline
  logic [CW-1:0]            count_r;
  logic signed [PW-1:0]     prod_r;
  logic signed [PW-1:0]     rnd_sum;
  logic signed [RW-1:0]     rnd_r;
  logic signed [RW:0]       ofs_sum;
  logic signed [DATA_W-1:0] y_sat;
  logic                     keep;

  // search window and compare state
  logic [CW-1:0]            lo_r;
  logic [CW-1:0]            hi_r;
  logic [AW-1:0]            mid_r;
  logic [CW:0]              mid_sum;
  logic [AW-1:0]            mid_nxt;
  logic [AW-1:0]            mid_dec;
  logic [CW-1:0]            last_idx;
  entry_t                   cur_r;
  entry_t                   prev_r;
  logic                     between_r;
  logic                     key_gt_r;
  logic                     key_lt_r;
  logic signed [DW-1:0]     d_hi_r;
  logic signed [DW-1:0]     d_lo_r;

  // memory ports
  logic                     ram_we;
  logic [AW-1:0]            ram_raddr;
  entry_t                   ram_wdata;
  entry_t                   ram_rdata;

  // result and output registers
  logic                     res_found_r;
  logic [AW-1:0]            res_idx_r;
  logic signed [DATA_W-1:0] res_x_r;
  logic signed [DATA_W-1:0] res_y_r;
  logic                     out_valid_r;
  logic                     out_found_r;
  logic [AW-1:0]            out_index_r;
  logic signed [DATA_W-1:0] out_near_x_r;
  logic signed [DATA_W-1:0] out_near_y_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r    <= MIN_X_RST;
      y_gain_r   <= Y_GAIN_RST;
      y_offset_r <= Y_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_X:    min_x_r    <= cfg_wdata;
        CFG_Y_GAIN:   y_gain_r   <= cfg_wdata[GAIN_W-1:0];
        CFG_Y_OFFSET: y_offset_r <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      x_r   <= in_sample_x;
      y_r   <= in_sample_y;
      key_r <= in_key;
    end
  end

  // y scaling: multiply, round half up to q16.16, add offset and saturate
  assign rnd_sum = prod_r + PW'(ROUND_HALF);
  assign ofs_sum = {rnd_r[RW-1], rnd_r} + (RW + 1)'(y_offset_r);

  always_comb begin
    if (ofs_sum[RW:DATA_W-1] == '0 || ofs_sum[RW:DATA_W-1] == '1) begin
      y_sat = ofs_sum[DATA_W-1:0];
    end else if (ofs_sum[RW]) begin
      y_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_mul) begin
      prod_r <= y_r * $signed({1'b0, y_gain_r});
    end
    if (cmd.ld_rnd) begin
      rnd_r <= rnd_sum[PW-1:FRAC_W];
    end
  end

  // a sample is stored when at or above the threshold and the table has room
  assign keep      = (x_r >= min_x_r) && (count_r < CW'(DEPTH));
  assign ram_we    = cmd.ld_wr && keep;
  assign ram_wdata = '{y: y_sat, x: x_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (ram_we) begin
      count_r <= count_r + CW'(1);
    end
  end

  // sample memory
  nss_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read address selection
  assign last_idx = count_r - CW'(1);
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_nxt  = mid_sum[AW:1];
  assign mid_dec  = mid_r - AW'(1);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_FIRST: ram_raddr = '0;
      RD_LAST:  ram_raddr = last_idx[AW-1:0];
      RD_MID:   ram_raddr = mid_nxt;
      RD_PREV:  ram_raddr = mid_dec;
      default:  ram_raddr = '0;
    endcase
  end

  // bisection window
  always_ff @(posedge clk) begin
    if (cmd.win_init) begin
      lo_r <= '0;
      hi_r <= count_r;
    end else if (cmd.win_lo) begin
      lo_r <= CW'(mid_r);
    end else if (cmd.win_hi) begin
      hi_r <= CW'(mid_r);
    end
    if (cmd.mid_calc) begin
      mid_r <= mid_nxt;
    end
  end

  // midpoint and neighbour capture, compares and distances
  always_ff @(posedge clk) begin
    if (cmd.cap_cur) begin
      cur_r <= ram_rdata;
    end
    if (cmd.cmp_load) begin
      prev_r    <= ram_rdata;
      between_r <= (mid_r != '0) && (ram_rdata.x < key_r) && (cur_r.x > key_r);
      key_gt_r  <= key_r > cur_r.x;
      key_lt_r  <= key_r < cur_r.x;
      d_hi_r    <= DW'(cur_r.x) - DW'(key_r);
      d_lo_r    <= DW'(key_r) - DW'(ram_rdata.x);
    end
  end

  // status to the controller
  assign sts.empty     = (count_r == '0);
  assign sts.ge_last   = key_r >= ram_rdata.x;
  assign sts.le_first  = key_r <= ram_rdata.x;
  assign sts.between   = between_r;
  assign sts.near_prev = d_hi_r >= d_lo_r;
  assign sts.key_gt    = key_gt_r;
  assign sts.key_lt    = key_lt_r;
  assign sts.lo_eq_mid = (lo_r == CW'(mid_r));
  assign sts.hi_eq_mid = (hi_r == CW'(mid_r));
  assign sts.out_free  = !out_valid_r || out_ready;

  // result selection
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        RES_EMPTY: begin
          res_found_r <= 1'b0;
          res_idx_r   <= '0;
          res_x_r     <= '0;
          res_y_r     <= '0;
        end
        RES_FIRST: begin
          res_found_r <= 1'b1;
          res_idx_r   <= '0;
          res_x_r     <= ram_rdata.x;
          res_y_r     <= ram_rdata.y;
        end
        RES_LAST: begin
          res_found_r <= 1'b1;
          res_idx_r   <= last_idx[AW-1:0];
          res_x_r     <= ram_rdata.x;
          res_y_r     <= ram_rdata.y;
        end
        RES_PREV: begin
          res_found_r <= 1'b1;
          res_idx_r   <= mid_dec;
          res_x_r     <= prev_r.x;
          res_y_r     <= prev_r.y;
        end
        default: begin
          res_found_r <= 1'b1;
          res_idx_r   <= mid_r;
          res_x_r     <= cur_r.x;
          res_y_r     <= cur_r.y;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found_r  <= res_found_r;
      out_index_r  <= res_idx_r;
      out_near_x_r <= res_x_r;
      out_near_y_r <= res_y_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_index  = out_index_r;
  assign out_near_x = out_near_x_r;
  assign out_near_y = out_near_y_r;

`ifndef NO_ASSERTIONS
  // the fill count never passes the table depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("sample count beyond table depth");

  // the bisection window stays ordered and inside the filled table
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mid_calc |-> (lo_r <= hi_r && hi_r <= count_r))
    else $error("search window out of order");

  // every midpoint read hits a written entry
  a_mid_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_cur |-> (CW'(mid_r) < count_r))
    else $error("midpoint read beyond filled table");
`endif

endmodule

@@ src/nearest_sample_search_top.sv @@
// Nearest sample search. Holds up to DEPTH (x, y) samples in Q16.16 in one
// memory of DEPTH x 64 bits with a single registered read port. A load runs
// through multiply, round, then offset and saturate together with the write;
// a clear is done on acceptance; neither gives a result. A query on an empty
// table goes straight to the output. Otherwise the last entry, then the first
// is checked, and the query ends there if the key lies at or beyond either;
// else it runs s bisection steps, s about log2 of the fill. In each step
// the midpoint and its lower neighbour are read one after the other through
// the one read port, then compared and the distances resolved. One
// transaction is in work at a time; a finished result waits in an output
// register while the next transaction is taken. The memory needs no clearing
// after reset: only entries below the fill count are ever used.

module nearest_sample_search_top
  import nss_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  nss_in_if.sink               in_ch,
  nss_out_if.source            out_ch
);

  nss_cmd_t cmd;
  nss_sts_t sts;

  // controller
  nss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  nss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_sample_x (in_ch.sample_x),
    .in_sample_y (in_ch.sample_y),
    .in_key      (in_ch.key),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_found   (out_ch.found),
    .out_index   (out_ch.index),
    .out_near_x  (out_ch.near_x),
    .out_near_y  (out_ch.near_y)
  );

endmodule
